@@ rtl/sle_pkg.sv @@
// Shared types and constants for the status LED serial encoder.
package sle_pkg;

	localparam int unsigned LED_BITS = 24;
	localparam int unsigned CNT_W = $clog2(LED_BITS);
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned PULSE_W = 8;
	localparam int unsigned LEVEL_W = 8;

	typedef enum logic [1:0] {
		REQ_FLAGS   = 2'd0,
		REQ_ARM     = 2'd1,
		REQ_REFRESH = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RGB_MODE   = 3'd0,
		CFG_BLINK_DUR  = 3'd1,
		CFG_LEVEL      = 3'd2,
		CFG_ONE_HIGH   = 3'd3,
		CFG_ONE_LOW    = 3'd4,
		CFG_ZERO_HIGH  = 3'd5,
		CFG_ZERO_LOW   = 3'd6
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} ser_state_t;

	// Load command from the request controller to the serializer.
	typedef struct packed {
		logic                load;
		logic                rgb;
		logic                plain;
		logic [LED_BITS-1:0] word;
	} sle_load_t;

	// Pulse timing set from the configuration registers.
	typedef struct packed {
		logic [PULSE_W-1:0] one_high;
		logic [PULSE_W-1:0] one_low;
		logic [PULSE_W-1:0] zero_high;
		logic [PULSE_W-1:0] zero_low;
	} sle_pulse_t;

	localparam logic [CFG_DATA_W-1:0] RST_BLINK_DUR = 24'd50000;
	localparam logic [LEVEL_W-1:0]    RST_LEVEL     = 8'd32;
	localparam logic [PULSE_W-1:0]    RST_ONE_HIGH  = 8'd84;
	localparam logic [PULSE_W-1:0]    RST_ONE_LOW   = 8'd72;
	localparam logic [PULSE_W-1:0]    RST_ZERO_HIGH = 8'd42;
	localparam logic [PULSE_W-1:0]    RST_ZERO_LOW  = 8'd96;

endpackage

@@ rtl/sle_if.sv @@
// Request and result channel interfaces of the status LED serial encoder.
interface sle_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic        keyboard_up;
	logic        mouse_up;
	logic [31:0] now_us;

	modport source (output valid, req_type, keyboard_up, mouse_up, now_us, input ready);
	modport sink (input valid, req_type, keyboard_up, mouse_up, now_us, output ready);
endinterface

interface sle_res_if;
	logic       valid;
	logic       ready;
	logic       bit_value;
	logic [7:0] high_cycles;
	logic [7:0] low_cycles;
	logic       plain_led_on;
	logic       last;

	modport source (output valid, bit_value, high_cycles, low_cycles, plain_led_on, last,
		input ready);
	modport sink (input valid, bit_value, high_cycles, low_cycles, plain_led_on, last,
		output ready);
endinterface

@@ rtl/sle_ctrl.sv @@
// Request controller: connection flags, blink deadline and colour choice.
module sle_ctrl
	import sle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            req_type,
	input  logic                  keyboard_up,
	input  logic                  mouse_up,
	input  logic [TIME_W-1:0]     now_us,
	input  logic                  rgb_mode,
	input  logic [CFG_DATA_W-1:0] blink_dur,
	input  logic [LEVEL_W-1:0]    level,
	output sle_load_t             load
);

	logic              kb_q;
	logic              ms_q;
	logic              armed_q;
	logic [TIME_W-1:0] deadline_q;

	logic              is_arm;
	logic              is_refresh;
	logic [TIME_W-1:0] add_b;
	logic [TIME_W-1:0] add_sum;
	logic              blinking;
	logic              connected;

	assign is_arm     = (req_type == REQ_ARM);
	assign is_refresh = (req_type == REQ_REFRESH);

	// One adder serves both requests: now + duration when arming,
	// now - deadline when refreshing.
	assign add_b   = is_arm ? {{(TIME_W-CFG_DATA_W){1'b0}}, blink_dur} : ~deadline_q;
	assign add_sum = now_us + add_b + {{(TIME_W-1){1'b0}}, ~is_arm};

	assign blinking  = armed_q & add_sum[TIME_W-1];
	assign connected = kb_q | ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q       <= 1'b0;
			ms_q       <= 1'b0;
			armed_q    <= 1'b0;
			deadline_q <= '0;
		end else if (accept) begin
			if (req_type == REQ_FLAGS) begin
				kb_q <= keyboard_up;
				ms_q <= mouse_up;
			end
			if (is_arm) begin
				deadline_q <= add_sum;
				armed_q    <= 1'b1;
			end
			if (is_refresh && !blinking) begin
				armed_q <= 1'b0;
			end
		end
	end

	always_comb begin
		load.load  = accept & is_refresh;
		load.rgb   = rgb_mode;
		load.plain = ~blinking & connected;
		if (blinking) begin
			load.word = {{(LED_BITS-LEVEL_W){1'b0}}, level};
		end else if (connected) begin
			load.word = {level, {(LED_BITS-LEVEL_W){1'b0}}};
		end else begin
			load.word = '0;
		end
	end

endmodule

@@ rtl/sle_ser.sv @@
// Serializer: shifts the GRB word out one bit descriptor per handshake.
module sle_ser
	import sle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sle_load_t  load,
	input  sle_pulse_t pulse,
	output logic       idle,
	sle_res_if.source  res
);

	ser_state_t          state_q;
	ser_state_t          state_d;
	logic [LED_BITS-1:0] word_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rgb_q;
	logic                plain_q;
	logic                take;
	logic                cur_bit;

	assign take    = res.valid & res.ready;
	assign cur_bit = word_q[LED_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idle    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (load.load) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (take && cnt_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load.load) begin
			word_q  <= load.word;
			rgb_q   <= load.rgb;
			plain_q <= load.plain;
			cnt_q   <= load.rgb ? CNT_W'(LED_BITS - 1) : '0;
		end else if (take) begin
			word_q <= {word_q[LED_BITS-2:0], 1'b0};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign res.valid        = (state_q == ST_SEND);
	assign res.bit_value    = rgb_q & cur_bit;
	assign res.high_cycles  = rgb_q ? (cur_bit ? pulse.one_high : pulse.zero_high) : '0;
	assign res.low_cycles   = rgb_q ? (cur_bit ? pulse.one_low : pulse.zero_low) : '0;
	assign res.plain_led_on = ~rgb_q & plain_q;
	assign res.last         = (cnt_q == '0);

endmodule

@@ rtl/status_led_ws2812_encoder.sv @@
// Top level of the status LED encoder with serial RGB bit descriptors.
//
// Requests arrive on the req channel (valid/ready). A flag request stores the
// keyboard and mouse connection flags, an arm request sets the blink deadline
// to now_us plus the configured duration, and a refresh request picks the LED
// colour: blue while the blink is running, green when connected, else off.
// Request code 3 is taken and dropped.
// Results leave on the res channel. In RGB mode a refresh gives 24 bit
// descriptors, green, red, blue, most significant bit first, each with its
// high and low pulse lengths; in simple mode it gives one plain on/off level.
// Flag and arm requests produce nothing. A refresh makes its first result
// valid in the cycle after it is taken; with the receiver always ready its
// descriptors follow back to back, and after the last one is taken the
// serializer returns to idle. The pace is set by the single shift register
// and its bit counter in the serializer.
// While results are pending req.ready is low; a stalled receiver simply
// holds the current descriptor until it is taken.
// Configuration writes are registered; the user must make them only while idle, as the block does not enforce it.
// Reset loads the register defaults, clears the flags and disarms the blink.
module status_led_ws2812_encoder
	import sle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sle_req_if.sink               req,
	sle_res_if.source             res
);

	logic                  rgb_mode_q;
	logic [CFG_DATA_W-1:0] blink_dur_q;
	logic [LEVEL_W-1:0]    level_q;
	sle_pulse_t            pulse_q;

	sle_load_t load;
	logic      idle;
	logic      accept;

	// Configuration registers, one write per cycle, unknown indexes ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_mode_q        <= 1'b1;
			blink_dur_q       <= RST_BLINK_DUR;
			level_q           <= RST_LEVEL;
			pulse_q.one_high  <= RST_ONE_HIGH;
			pulse_q.one_low   <= RST_ONE_LOW;
			pulse_q.zero_high <= RST_ZERO_HIGH;
			pulse_q.zero_low  <= RST_ZERO_LOW;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RGB_MODE:  rgb_mode_q        <= cfg_wdata[0];
				CFG_BLINK_DUR: blink_dur_q       <= cfg_wdata;
				CFG_LEVEL:     level_q           <= cfg_wdata[LEVEL_W-1:0];
				CFG_ONE_HIGH:  pulse_q.one_high  <= cfg_wdata[PULSE_W-1:0];
				CFG_ONE_LOW:   pulse_q.one_low   <= cfg_wdata[PULSE_W-1:0];
				CFG_ZERO_HIGH: pulse_q.zero_high <= cfg_wdata[PULSE_W-1:0];
				CFG_ZERO_LOW:  pulse_q.zero_low  <= cfg_wdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// A request is taken only while the serializer has nothing left to send.
	assign req.ready = idle;
	assign accept    = req.valid & idle;

	sle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req_type    (req.req_type),
		.keyboard_up (req.keyboard_up),
		.mouse_up    (req.mouse_up),
		.now_us      (req.now_us),
		.rgb_mode    (rgb_mode_q),
		.blink_dur   (blink_dur_q),
		.level       (level_q),
		.load        (load)
	);

	sle_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.pulse  (pulse_q),
		.idle   (idle),
		.res    (res)
	);

	// No request is taken while a result is still on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !res.valid)
		else $error("request taken while results pending");

	// A refresh always yields a valid result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == REQ_REFRESH) |=> res.valid)
		else $error("refresh produced no result");

	// After the last result is taken the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && res.last) |=> (req.ready && !res.valid))
		else $error("block not idle after last result");

	// A lit simple-mode level is a single, final result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.plain_led_on) |-> (res.last && res.high_cycles == '0))
		else $error("simple-mode result malformed");

endmodule
